// ----- rtl/lcsbe_pkg.sv -----
// Shared types and constants for the LED color SPI bit expander.
package lcsbe_pkg;

   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned LEVEL_W     = 8;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned PCT_W       = 7;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned SYM_W       = 8;

   localparam int unsigned BITS_PER_LED = 24;
   localparam int unsigned BIT_CNT_W    = 5;

   // Scaled channel: (c * p + 50) / 100, division done as (x * 5243) >> 19,
   // exact for x below 43690; x never exceeds 25550.
   localparam int unsigned PROD_W      = 15;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned QUOT_FULL_W = PROD_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic [PROD_W-1:0]      ROUND_BIAS = PROD_W'(50);
   localparam logic [RECIP_W-1:0]     RECIP_MUL  = RECIP_W'(5243);

   // reciprocal split into a low and a high slice, summed one stage later
   localparam int unsigned RECIP_LO_W  = 7;
   localparam int unsigned RECIP_HI_W  = RECIP_W - RECIP_LO_W;
   localparam int unsigned PLO_W       = PROD_W + RECIP_LO_W;
   localparam int unsigned PHI_W       = PROD_W + RECIP_HI_W;

   localparam logic [RECIP_LO_W-1:0]  RECIP_LO = RECIP_MUL[RECIP_LO_W-1:0];
   localparam logic [RECIP_HI_W-1:0]  RECIP_HI = RECIP_MUL[RECIP_W-1:RECIP_LO_W];

   localparam logic [COUNT_W-1:0]     MAX_LEDS           = COUNT_W'(1024);
   localparam logic [COUNT_W-1:0]     LED_COUNT_RESET    = COUNT_W'(1024);
   localparam logic [PCT_W-1:0]       BRIGHTNESS_RESET   = PCT_W'(100);
   localparam logic [PCT_W-1:0]       BRIGHTNESS_MAX     = PCT_W'(100);
   localparam logic [BIT_CNT_W-1:0]   LAST_BIT           = BIT_CNT_W'(BITS_PER_LED - 1);

   localparam logic [SYM_W-1:0]       SYM_ONE   = 8'hE0;
   localparam logic [SYM_W-1:0]       SYM_ZERO  = 8'h80;
   localparam logic [SYM_W-1:0]       SYM_ERROR = 8'h00;

   typedef enum logic [0:0] {
      CSR_LED_COUNT  = 1'b0,
      CSR_BRIGHTNESS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
   } req_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] spi_byte;
      logic             last_byte;
      logic             index_error;
   } rsp_payload_type;

endpackage

// ----- rtl/led_color_spi_bit_expander.sv -----
// Top level: scales one LED color, packs GRB and expands it into SPI symbol bytes.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_payload_type (index, red, green, blue)
//  rsp_      out        rsp_valid/rsp_stall  rsp_payload_type (spi_byte, last_byte, index_error)
//  csr_      in         csr_write            csr_index, csr_wdata
//
// A word passes three register stages (range check and c*p, reciprocal partial
// products, partial sum and pack) and then the serializer, which shifts out one
// byte per cycle while rsp_stall is low: 24 bytes per in-range LED, one byte per
// rejected index. The serializer sets the rate. Reset (synchronous) empties every
// stage and restores led_count 1024 and brightness 100. Stalls back up stage by
// stage; no word is dropped or repeated.
module led_color_spi_bit_expander (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lcsbe_pkg::req_payload_type             req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lcsbe_pkg::rsp_payload_type             rsp_payload,
   input  logic                                   csr_write,
   input  lcsbe_pkg::csr_index_type               csr_index,
   input  logic [lcsbe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration
   logic [lcsbe_pkg::COUNT_W-1:0] led_count_ff;
   logic [lcsbe_pkg::PCT_W-1:0]   brightness_ff;
   logic [lcsbe_pkg::COUNT_W-1:0] limit;
   logic [lcsbe_pkg::PCT_W-1:0]   bright_wdata;

   // stage 1: range check and channel products
   logic                          v1_ff;
   logic                          err1_ff;
   logic [lcsbe_pkg::PROD_W-1:0]  prod_r1_ff, prod_g1_ff, prod_b1_ff;

   // stage 2: reciprocal partial products
   logic                               v2_ff;
   logic                               err2_ff;
   logic [lcsbe_pkg::PLO_W-1:0]        plo_r2_ff, plo_g2_ff, plo_b2_ff;
   logic [lcsbe_pkg::PLO_W-1:0]        plo_r2_in, plo_g2_in, plo_b2_in;
   logic [lcsbe_pkg::PHI_W-1:0]        phi_r2_ff, phi_g2_ff, phi_b2_ff;
   logic [lcsbe_pkg::PHI_W-1:0]        phi_r2_in, phi_g2_in, phi_b2_in;

   // stage 3: packed GRB word
   logic                                  v3_ff;
   logic                                  err3_ff;
   logic [lcsbe_pkg::QUOT_FULL_W-1:0]     quot_r3, quot_g3, quot_b3;
   logic [lcsbe_pkg::BITS_PER_LED-1:0]    word3_ff;
   logic [lcsbe_pkg::BITS_PER_LED-1:0]    word3_in;

   // serializer
   logic                                  ser_valid_ff;
   logic                                  ser_err_ff;
   logic [lcsbe_pkg::BITS_PER_LED-1:0]    ser_word_ff;
   logic [lcsbe_pkg::BIT_CNT_W-1:0]       ser_cnt_ff;

   logic take1, take2, take3;
   logic req_fire, rsp_fire, rsp_last, ser_load;

   always_comb begin
      limit = (led_count_ff > lcsbe_pkg::MAX_LEDS) ? lcsbe_pkg::MAX_LEDS : led_count_ff;
      bright_wdata = csr_wdata[lcsbe_pkg::PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff  <= lcsbe_pkg::LED_COUNT_RESET;
         brightness_ff <= lcsbe_pkg::BRIGHTNESS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lcsbe_pkg::CSR_LED_COUNT: begin
               led_count_ff <= csr_wdata[lcsbe_pkg::COUNT_W-1:0];
            end
            lcsbe_pkg::CSR_BRIGHTNESS: begin
               // drop out-of-range percentages
               if (bright_wdata <= lcsbe_pkg::BRIGHTNESS_MAX) begin
                  brightness_ff <= bright_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // handshake and stage advance
   always_comb begin
      rsp_last = ser_err_ff || (ser_cnt_ff == lcsbe_pkg::LAST_BIT);
      rsp_fire = ser_valid_ff && !rsp_stall;
      ser_load = v3_ff && (!ser_valid_ff || (rsp_fire && rsp_last));
      take3    = !v3_ff || ser_load;
      take2    = !v2_ff || take3;
      take1    = !v1_ff || take2;
      req_stall = !take1;
      req_fire  = req_valid && take1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (take1) begin
            v1_ff <= req_valid;
         end
         if (take2) begin
            v2_ff <= v1_ff;
         end
         if (take3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err1_ff    <= req_payload.led_index >= lcsbe_pkg::INDEX_W'(limit);
         prod_r1_ff <= lcsbe_pkg::PROD_W'(req_payload.red_level)
                       * lcsbe_pkg::PROD_W'(brightness_ff);
         prod_g1_ff <= lcsbe_pkg::PROD_W'(req_payload.green_level)
                       * lcsbe_pkg::PROD_W'(brightness_ff);
         prod_b1_ff <= lcsbe_pkg::PROD_W'(req_payload.blue_level)
                       * lcsbe_pkg::PROD_W'(brightness_ff);
      end
   end

   always_comb begin
      plo_r2_in = lcsbe_pkg::PLO_W'(prod_r1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PLO_W'(lcsbe_pkg::RECIP_LO);
      plo_g2_in = lcsbe_pkg::PLO_W'(prod_g1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PLO_W'(lcsbe_pkg::RECIP_LO);
      plo_b2_in = lcsbe_pkg::PLO_W'(prod_b1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PLO_W'(lcsbe_pkg::RECIP_LO);
      phi_r2_in = lcsbe_pkg::PHI_W'(prod_r1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PHI_W'(lcsbe_pkg::RECIP_HI);
      phi_g2_in = lcsbe_pkg::PHI_W'(prod_g1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PHI_W'(lcsbe_pkg::RECIP_HI);
      phi_b2_in = lcsbe_pkg::PHI_W'(prod_b1_ff + lcsbe_pkg::ROUND_BIAS)
                  * lcsbe_pkg::PHI_W'(lcsbe_pkg::RECIP_HI);
   end

   always_ff @(posedge clock) begin
      if (take2 && v1_ff) begin
         err2_ff   <= err1_ff;
         plo_r2_ff <= plo_r2_in;
         plo_g2_ff <= plo_g2_in;
         plo_b2_ff <= plo_b2_in;
         phi_r2_ff <= phi_r2_in;
         phi_g2_ff <= phi_g2_in;
         phi_b2_ff <= phi_b2_in;
      end
   end

   // combine the slices, then pack green, red, blue order, MSB first
   always_comb begin
      quot_r3 = lcsbe_pkg::QUOT_FULL_W'(plo_r2_ff)
                + (lcsbe_pkg::QUOT_FULL_W'(phi_r2_ff) << lcsbe_pkg::RECIP_LO_W);
      quot_g3 = lcsbe_pkg::QUOT_FULL_W'(plo_g2_ff)
                + (lcsbe_pkg::QUOT_FULL_W'(phi_g2_ff) << lcsbe_pkg::RECIP_LO_W);
      quot_b3 = lcsbe_pkg::QUOT_FULL_W'(plo_b2_ff)
                + (lcsbe_pkg::QUOT_FULL_W'(phi_b2_ff) << lcsbe_pkg::RECIP_LO_W);
      word3_in = {quot_g3[lcsbe_pkg::RECIP_SHIFT +: lcsbe_pkg::LEVEL_W],
                  quot_r3[lcsbe_pkg::RECIP_SHIFT +: lcsbe_pkg::LEVEL_W],
                  quot_b3[lcsbe_pkg::RECIP_SHIFT +: lcsbe_pkg::LEVEL_W]};
   end

   always_ff @(posedge clock) begin
      if (take3 && v2_ff) begin
         err3_ff  <= err2_ff;
         word3_ff <= word3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else if (ser_load) begin
         ser_valid_ff <= 1'b1;
      end else if (rsp_fire && rsp_last) begin
         ser_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_err_ff  <= err3_ff;
         ser_word_ff <= word3_ff;
         ser_cnt_ff  <= '0;
      end else if (rsp_fire && !rsp_last) begin
         // advance to the next bit
         ser_word_ff <= {ser_word_ff[lcsbe_pkg::BITS_PER_LED-2:0], 1'b0};
         ser_cnt_ff  <= ser_cnt_ff + lcsbe_pkg::BIT_CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid = ser_valid_ff;
      rsp_payload.last_byte   = rsp_last;
      rsp_payload.index_error = ser_err_ff;
      if (ser_err_ff) begin
         rsp_payload.spi_byte = lcsbe_pkg::SYM_ERROR;
      end else if (ser_word_ff[lcsbe_pkg::BITS_PER_LED-1]) begin
         rsp_payload.spi_byte = lcsbe_pkg::SYM_ONE;
      end else begin
         rsp_payload.spi_byte = lcsbe_pkg::SYM_ZERO;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> ser_cnt_ff <= lcsbe_pkg::LAST_BIT)
      else $error("serializer bit count out of range");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (ser_valid_ff && ser_err_ff) |-> ser_cnt_ff == '0)
      else $error("index error word emitted more than one byte");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=> ser_valid_ff)
      else $error("serializer dropped a word before its last byte");

   a_bright_range: assert property (@(posedge clock) disable iff (reset)
      brightness_ff <= lcsbe_pkg::BRIGHTNESS_MAX)
      else $error("brightness above limit");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && ser_valid_ff))
      else $error("input stalled with an empty stage");
`endif

endmodule

// ----- test/led_color_spi_bit_expander_tb.sv -----
// Testbench for the LED color SPI bit expander: predicts the SPI symbol bytes and checks them.
`timescale 1ns / 1ps

module led_color_spi_bit_expander_tb;

   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned MAX_REPORTS      = 10;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   lcsbe_pkg::req_payload_type          req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   lcsbe_pkg::rsp_payload_type          rsp_payload;
   logic                                csr_write   = 1'b0;
   lcsbe_pkg::csr_index_type            csr_index   = lcsbe_pkg::CSR_LED_COUNT;
   logic [lcsbe_pkg::CSR_DATA_W-1:0]    csr_wdata   = '0;

   // local copy of the two registers
   logic [lcsbe_pkg::COUNT_W-1:0]  led_count_model  = lcsbe_pkg::LED_COUNT_RESET;
   logic [lcsbe_pkg::PCT_W-1:0]    brightness_model = lcsbe_pkg::BRIGHTNESS_RESET;

   lcsbe_pkg::req_payload_type     pending_words[$];
   lcsbe_pkg::rsp_payload_type     expected_bytes[$];
   lcsbe_pkg::rsp_payload_type     front_byte;
   int unsigned             mismatch_count     = 0;
   int unsigned             sender_idle_pct    = 0;
   int unsigned             receiver_stall_pct = 0;
   logic                    long_hold_start    = 1'b0;
   int unsigned             long_hold_left     = 0;

   led_color_spi_bit_expander i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   function automatic logic [lcsbe_pkg::COUNT_W-1:0] effective_leds();
      return (led_count_model > lcsbe_pkg::MAX_LEDS) ? lcsbe_pkg::MAX_LEDS : led_count_model;
   endfunction

   // (c * p + 50) / 100, i.e. c * p / 100 rounded half up
   function automatic logic [lcsbe_pkg::LEVEL_W-1:0] scaled_level(
      logic [lcsbe_pkg::LEVEL_W-1:0] level);
      int unsigned x;
      x = (32'(level) * 32'(brightness_model) + 50) / 100;
      return x[lcsbe_pkg::LEVEL_W-1:0];
   endfunction

   function automatic void predict_bytes(lcsbe_pkg::req_payload_type w);
      logic [3*lcsbe_pkg::LEVEL_W-1:0] grb;
      lcsbe_pkg::rsp_payload_type      r;
      if (w.led_index >= lcsbe_pkg::INDEX_W'(effective_leds())) begin
         r.spi_byte    = lcsbe_pkg::SYM_ERROR;
         r.last_byte   = 1'b1;
         r.index_error = 1'b1;
         expected_bytes.push_back(r);
      end else begin
         grb = {scaled_level(w.green_level), scaled_level(w.red_level),
                scaled_level(w.blue_level)};
         for (int k = lcsbe_pkg::BITS_PER_LED - 1; k >= 0; k--) begin
            r.spi_byte    = grb[k] ? lcsbe_pkg::SYM_ONE : lcsbe_pkg::SYM_ZERO;
            r.last_byte   = (k == 0);
            r.index_error = 1'b0;
            expected_bytes.push_back(r);
         end
      end
   endfunction

   function automatic void add_word(int unsigned idx, int unsigned red, int unsigned green,
                                    int unsigned blue);
      lcsbe_pkg::req_payload_type w;
      w.led_index   = lcsbe_pkg::INDEX_W'(idx);
      w.red_level   = lcsbe_pkg::LEVEL_W'(red);
      w.green_level = lcsbe_pkg::LEVEL_W'(green);
      w.blue_level  = lcsbe_pkg::LEVEL_W'(blue);
      pending_words.push_back(w);
   endfunction

   // mostly in-range indices so that most words expand into full byte runs
   task automatic add_random_words(int unsigned n);
      int unsigned lim;
      int unsigned idx;
      lim = 32'(effective_leds());
      repeat (n) begin
         if (lim != 0 && $urandom_range(99) < 80) idx = $urandom_range(lim - 1);
         else idx = $urandom_range(4095);
         add_word(idx, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
   endtask

   task automatic set_config(logic [lcsbe_pkg::COUNT_W-1:0] count,
                             logic [lcsbe_pkg::PCT_W-1:0] pct);
      csr_write <= 1'b1;
      csr_index <= lcsbe_pkg::CSR_LED_COUNT;
      csr_wdata <= lcsbe_pkg::CSR_DATA_W'(count);
      @(posedge clock);
      csr_index <= lcsbe_pkg::CSR_BRIGHTNESS;
      csr_wdata <= lcsbe_pkg::CSR_DATA_W'(pct);
      @(posedge clock);
      csr_write <= 1'b0;
      led_count_model = count;
      if (pct <= lcsbe_pkg::BRIGHTNESS_MAX) brightness_model = pct;
   endtask

   // sample at the falling edge so the driver and monitor updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_byte(string what, lcsbe_pkg::rsp_payload_type want,
                              lcsbe_pkg::rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%s: expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                  what, want.spi_byte, want.last_byte, want.index_error,
                  got.spi_byte, got.last_byte, got.index_error);
   endtask

   // driver: advance to the next word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_bytes(req_payload);
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_payload <= pending_words.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold so the pipeline backs up into the input
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
      end else if (long_hold_start) begin
         long_hold_left <= LONG_HOLD_CYCLES;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_byte("byte with nothing expected", '0, rsp_payload);
            end else begin
               front_byte = expected_bytes.pop_front();
               if (rsp_payload.spi_byte !== front_byte.spi_byte ||
                   rsp_payload.last_byte !== front_byte.last_byte ||
                   rsp_payload.index_error !== front_byte.index_error)
                  report_byte("byte mismatch", front_byte, rsp_payload);
            end
         end
         rsp_stall <= (long_hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
      end
   end

   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes and the range boundary
      add_word(0, 0, 0, 0);
      add_word(1023, 255, 255, 255);
      add_word(1024, 255, 255, 255);
      add_word(4095, 0, 0, 0);
      add_word(2048, 17, 34, 51);
      add_word(512, 8'h80, 8'h01, 8'hAA);
      add_word(1, 8'h55, 8'hFE, 8'h7F);
      add_random_words(10);
      wait_idle();

      // count above the strip size saturates; halves round up
      set_config(2047, 50);
      add_word(1023, 1, 255, 0);
      add_word(1024, 9, 9, 9);
      add_word(0, 3, 101, 199);
      add_random_words(25);
      wait_idle();

      // brightness above 100 is dropped, 50 stays
      sender_idle_pct = 67;
      set_config(300, 127);
      add_random_words(30);
      wait_idle();

      sender_idle_pct    = 0;
      receiver_stall_pct = 67;
      set_config(1, 0);
      add_word(0, 255, 255, 255);
      add_random_words(30);
      wait_idle();

      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      set_config(1023, 99);
      add_random_words(30);
      wait_idle();

      // empty strip: every word is rejected
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      set_config(0, 101);
      add_word(0, 255, 0, 255);
      add_random_words(9);
      wait_idle();

      set_config(5, 1);
      add_word(4, 49, 50, 255);
      add_word(5, 255, 255, 255);
      add_random_words(8);
      wait_idle();

      set_config(1024, 100);
      long_hold_start <= 1'b1;
      @(posedge clock);
      long_hold_start <= 1'b0;
      add_random_words(30);
      wait_idle();

      receiver_stall_pct = 67;
      add_random_words(15);
      wait_idle();

      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      add_random_words(15);
      wait_idle();

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lcsbe_pkg.sv
rtl/led_color_spi_bit_expander.sv
test/led_color_spi_bit_expander_tb.sv
